FILE: rtl/aiop_pkg.sv
// ----------------------------------------------------------------------------
// aiop_pkg
// Shared types and constants of the arcade I/O page with protection device.
// ----------------------------------------------------------------------------
`default_nettype none

package aiop_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int BTN_W     = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PORT0_DEFAULT      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT1_DEFAULT      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT2_DEFAULT_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT2_DEFAULT_HIGH = 4'd3;

  // access kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // read map
  localparam logic [15:0] ADDR_PORT0 = 16'h9800;
  localparam logic [15:0] ADDR_PORT1 = 16'h9801;
  localparam logic [15:0] ADDR_PORT2 = 16'h9802;
  // write map
  localparam logic [15:0] ADDR_SOUND_CMD   = 16'ha000;
  localparam logic [15:0] ADDR_SOUND_IRQ   = 16'ha001;
  localparam logic [15:0] ADDR_PROT        = 16'ha002;
  localparam logic [15:0] ADDR_NMI         = 16'ha801;
  localparam logic [15:0] ADDR_BACKGROUND  = 16'ha803;
  localparam logic [15:0] ADDR_STARS       = 16'ha804;

  localparam logic [7:0] BYTE_NONE = 8'hff;

  // button bit positions
  localparam int BTN_COIN  = 0;
  localparam int BTN_LEFT  = 1;
  localparam int BTN_RIGHT = 2;
  localparam int BTN_FIRE  = 3;
  localparam int BTN_START = 4;
  localparam int BTN_DOWN  = 5;
  localparam int BTN_UP    = 6;

  // sound irq line is bit 3 of the written byte
  localparam int IRQ_BIT = 3;

  // protection opcodes (new low nibble)
  localparam logic [3:0] PROT_OP_TOGGLE = 4'h6;
  localparam logic [3:0] PROT_OP_INC    = 4'h9;
  localparam logic [3:0] PROT_OP_CLEAR  = 4'ha;
  localparam logic [3:0] PROT_OP_SUB_BA = 4'hb;
  localparam logic [3:0] PROT_OP_SUB_AB = 4'hf;

  typedef struct packed {
    logic             req_type;
    logic [15:0]      bus_address;
    logic [7:0]       write_byte;
    logic [BTN_W-1:0] buttons;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_enable;
    logic       background_on;
    logic       stars_on;
    logic       play_started;
    logic [7:0] sound_command;
    logic [7:0] sound_irq_value;
    logic       sound_irq_strobe;
  } rsp_t;

  typedef struct packed {
    logic [7:0] port0_default;
    logic [7:0] port1_default;
    logic [7:0] port2_default_low;
    logic [7:0] port2_default_high;
  } cfg_t;

  // new protection result from the already shifted register
  function automatic logic [7:0] prot_update(input logic [11:0] shift,
                                             input logic [7:0]  result);
    logic [3:0] a;
    logic [3:0] b;
    logic [7:0] r;
    a = shift[11:8];
    b = shift[7:4];
    r = result;
    case (shift[3:0])
      PROT_OP_TOGGLE: r = result ^ 8'h80;
      PROT_OP_INC:    r = {((a == 4'hf) ? 4'hf : a + 4'd1), 4'h0};
      PROT_OP_SUB_BA: r = {((b > a) ? b - a : 4'h0), 4'h0};
      PROT_OP_CLEAR:  r = 8'h00;
      PROT_OP_SUB_AB: r = {((a > b) ? a - b : 4'h0), 4'h0};
      default:        r = result;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aiop_cfg.sv
// ----------------------------------------------------------------------------
// aiop_cfg
// Configuration registers: idle values of the three input ports.
// ----------------------------------------------------------------------------
`default_nettype none

module aiop_cfg
  import aiop_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output cfg_t                      cfg
);

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.port0_default      <= 8'hff;
      regs.port1_default      <= 8'hff;
      regs.port2_default_low  <= 8'hff;
      regs.port2_default_high <= 8'hff;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PORT0_DEFAULT:      regs.port0_default      <= cfg_data;
        CFG_PORT1_DEFAULT:      regs.port1_default      <= cfg_data;
        CFG_PORT2_DEFAULT_LOW:  regs.port2_default_low  <= cfg_data;
        CFG_PORT2_DEFAULT_HIGH: regs.port2_default_high <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aiop_core.sv
// ----------------------------------------------------------------------------
// aiop_core
// Bus decode, port merge, latches, sound irq edge capture and protection.
// ----------------------------------------------------------------------------
`default_nettype none

module aiop_core
  import aiop_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output rsp_t      rsp
);

  logic [11:0] prot_shift;
  logic [7:0]  prot_result;
  logic        fire_locked;
  logic [7:0]  sound_cmd;
  logic        irq_line_prev;
  logic [7:0]  irq_capture;
  logic        nmi_enable;
  logic        background_on;
  logic        stars_on;
  logic        play_started;

  logic [11:0] prot_shift_next;
  logic [7:0]  prot_result_next;
  logic        fire_locked_next;
  logic [7:0]  sound_cmd_next;
  logic        irq_line_prev_next;
  logic [7:0]  irq_capture_next;
  logic        nmi_enable_next;
  logic        background_on_next;
  logic        stars_on_next;
  logic        play_started_next;
  logic [7:0]  rd;
  logic        strobe;
  logic        fire_open;

  always_comb begin
    prot_shift_next    = prot_shift;
    prot_result_next   = prot_result;
    fire_locked_next   = fire_locked;
    sound_cmd_next     = sound_cmd;
    irq_line_prev_next = irq_line_prev;
    irq_capture_next   = irq_capture;
    nmi_enable_next    = nmi_enable;
    background_on_next = background_on;
    stars_on_next      = stars_on;
    play_started_next  = play_started;
    rd                 = BYTE_NONE;
    strobe             = 1'b0;
    // lockout released by start without fire, already for this read
    fire_open = !fire_locked ||
                (!req.buttons[BTN_FIRE] && req.buttons[BTN_START]);

    if (req.req_type == REQ_WRITE) begin
      unique case (req.bus_address)
        ADDR_SOUND_CMD: sound_cmd_next = req.write_byte;
        ADDR_SOUND_IRQ: begin
          if (req.write_byte[IRQ_BIT] && !irq_line_prev) begin
            irq_capture_next = req.write_byte;
            strobe           = 1'b1;
          end
          irq_line_prev_next = req.write_byte[IRQ_BIT];
        end
        ADDR_PROT: begin
          prot_shift_next  = {prot_shift[7:0], req.write_byte[3:0]};
          prot_result_next = prot_update({prot_shift[7:0], req.write_byte[3:0]},
                                         prot_result);
        end
        ADDR_NMI:        nmi_enable_next = req.write_byte[0];
        ADDR_BACKGROUND: begin
          background_on_next = req.write_byte[0];
          play_started_next  = 1'b1;
        end
        ADDR_STARS:      stars_on_next = req.write_byte[0];
        default: ;
      endcase
    end else begin
      unique case (req.bus_address)
        ADDR_PORT0: begin
          rd = cfg.port0_default;
          if (req.buttons[BTN_COIN])  rd[7] = 1'b0;
          if (req.buttons[BTN_LEFT])  rd[5] = 1'b0;
          if (req.buttons[BTN_RIGHT]) rd[4] = 1'b0;
          fire_locked_next = !fire_open;
          if (fire_open && req.buttons[BTN_FIRE]) begin
            rd[3] = 1'b0;
            rd[1] = 1'b0;
          end
        end
        ADDR_PORT1: begin
          rd = cfg.port1_default;
          if (!fire_locked && req.buttons[BTN_START]) rd[7] = 1'b0;
        end
        ADDR_PORT2: begin
          rd = prot_result[7] ? cfg.port2_default_high : cfg.port2_default_low;
          if (req.buttons[BTN_DOWN]) rd[6] = 1'b0;
          if (req.buttons[BTN_UP])   rd[4] = 1'b0;
        end
        ADDR_PROT: rd = prot_result;
        default: ;
      endcase
    end

    rsp.read_data        = rd;
    rsp.nmi_enable       = nmi_enable_next;
    rsp.background_on    = background_on_next;
    rsp.stars_on         = stars_on_next;
    rsp.play_started     = play_started_next;
    rsp.sound_command    = sound_cmd_next;
    rsp.sound_irq_value  = irq_capture_next;
    rsp.sound_irq_strobe = strobe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prot_shift    <= 12'h000;
      prot_result   <= 8'h00;
      fire_locked   <= 1'b1;
      sound_cmd     <= 8'h00;
      irq_line_prev <= 1'b0;
      irq_capture   <= 8'h00;
      nmi_enable    <= 1'b0;
      background_on <= 1'b0;
      stars_on      <= 1'b0;
      play_started  <= 1'b0;
    end else if (step) begin
      prot_shift    <= prot_shift_next;
      prot_result   <= prot_result_next;
      fire_locked   <= fire_locked_next;
      sound_cmd     <= sound_cmd_next;
      irq_line_prev <= irq_line_prev_next;
      irq_capture   <= irq_capture_next;
      nmi_enable    <= nmi_enable_next;
      background_on <= background_on_next;
      stars_on      <= stars_on_next;
      play_started  <= play_started_next;
    end
  end

`ifndef ASSERT_OFF
  // the captured irq byte always has the line bit high
  a_capture_bit: assert property (@(posedge clk) disable iff (rst)
    (irq_capture != 8'h00) |-> irq_capture[IRQ_BIT])
    else $error("irq capture without line bit");

  // a strobe needs the line low before and high after
  a_strobe_edge: assert property (@(posedge clk) disable iff (rst)
    (step && strobe) |=> (irq_line_prev && !$past(irq_line_prev)))
    else $error("irq strobe without rising edge");
`endif

endmodule

`default_nettype wire

FILE: rtl/arcade_io_page_with_protection.sv
// ----------------------------------------------------------------------------
// arcade_io_page_with_protection
// I/O page of the main CPU: input ports, control latches, sound command and
// irq capture, and the nibble-shift protection device.
// ----------------------------------------------------------------------------
// pipeline: the input register loads at accept and the result register loads
//   from it when the output is free; decode sits between
// throughput: one request per cycle while the output is not stalled
// reset: synchronous rst clears both valid stages and the device state,
//   sets the fire lockout and loads all port idle values with 0xff
`default_nettype none

module arcade_io_page_with_protection
  import aiop_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 req_type,
  input  wire logic [15:0]          bus_address,
  input  wire logic [7:0]           write_byte,
  input  wire logic [BTN_W-1:0]     buttons,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                read_data,
  output logic                      nmi_enable,
  output logic                      background_on,
  output logic                      stars_on,
  output logic                      play_started,
  output logic [7:0]                sound_command,
  output logic [7:0]                sound_irq_value,
  output logic                      sound_irq_strobe,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t cfg;
  req_t a_req;
  logic a_valid;
  rsp_t core_rsp;
  rsp_t out_rsp;
  logic out_free;
  logic adv;
  logic in_take;

  assign out_free = !out_valid || !out_stall;
  assign adv      = a_valid && out_free;
  assign in_stall = a_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  aiop_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aiop_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .req  (a_req),
    .cfg  (cfg),
    .rsp  (core_rsp)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_req.req_type    <= req_type;
      a_req.bus_address <= bus_address;
      a_req.write_byte  <= write_byte;
      a_req.buttons     <= buttons;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rsp <= core_rsp;
    end
  end

  assign read_data        = out_rsp.read_data;
  assign nmi_enable       = out_rsp.nmi_enable;
  assign background_on    = out_rsp.background_on;
  assign stars_on         = out_rsp.stars_on;
  assign play_started     = out_rsp.play_started;
  assign sound_command    = out_rsp.sound_command;
  assign sound_irq_value  = out_rsp.sound_irq_value;
  assign sound_irq_strobe = out_rsp.sound_irq_strobe;

`ifndef ASSERT_OFF
  // back-pressure only comes from a full input register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid)
    else $error("stall with empty input register");

  // a held request is not dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !adv) |=> a_valid)
    else $error("input register lost a request");

  // background latch is only set together with play started
  a_play: assert property (@(posedge clk) disable iff (rst)
    (out_valid && background_on) |-> play_started)
    else $error("background on without play started");

  // a strobed result always carries a byte with the irq line set
  a_strobe_val: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sound_irq_strobe) |-> sound_irq_value[IRQ_BIT])
    else $error("strobe without irq line bit");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_arcade_io_page_with_protection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arcade_io_page_with_protection
// Self-checking bench for the arcade I/O page. A short directed list covers
// lockout, port merging, latches, the sound irq edge and the protection ops,
// then random bus traffic runs under several idle/stall mixes. Every response
// is compared field by field against an in-bench model of the page.
// ----------------------------------------------------------------------------

module tb_arcade_io_page_with_protection;
  import aiop_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 160;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'hf;

  typedef struct packed {
    req_t       rq;
    logic       chk;
    logic [7:0] rd;
  } dir_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 req_type = REQ_READ;
  logic [15:0]          bus_address = 16'h0000;
  logic [7:0]           write_byte = 8'h00;
  logic [BTN_W-1:0]     buttons = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           read_data;
  logic                 nmi_enable;
  logic                 background_on;
  logic                 stars_on;
  logic                 play_started;
  logic [7:0]           sound_command;
  logic [7:0]           sound_irq_value;
  logic                 sound_irq_strobe;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PORT0_DEFAULT;
  logic [7:0]           cfg_data = 8'h00;

  // bench copy of the page state
  cfg_t        port_cfg      = {8'hff, 8'hff, 8'hff, 8'hff};
  logic [11:0] prot_shift_q  = 12'h000;
  logic [7:0]  prot_value_q  = 8'h00;
  logic        fire_lock_q   = 1'b1;
  logic [7:0]  snd_latch_q   = 8'h00;
  logic        irq_prev_q    = 1'b0;
  logic [7:0]  irq_byte_q    = 8'h00;
  logic [3:0]  ctrl_q        = 4'h0;

  rsp_t     pending_responses [$];
  dir_row_t dir_rows [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       stall_pct = 0;
  int       hold_ticket = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  arcade_io_page_with_protection u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .bus_address      (bus_address),
    .write_byte       (write_byte),
    .buttons          (buttons),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_data        (read_data),
    .nmi_enable       (nmi_enable),
    .background_on    (background_on),
    .stars_on         (stars_on),
    .play_started     (play_started),
    .sound_command    (sound_command),
    .sound_irq_value  (sound_irq_value),
    .sound_irq_strobe (sound_irq_strobe),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // response of the page to one bus access, advancing the bench state
  task automatic compute_io_response(input req_t r, output rsp_t o);
    logic [7:0] v;
    logic [4:0] inc;
    logic [3:0] a;
    logic [3:0] b;
    logic       strobe;
    v = BYTE_NONE;
    strobe = 1'b0;
    if (r.req_type == REQ_READ) begin
      case (r.bus_address)
        ADDR_PORT0: begin
          v = port_cfg.port0_default;
          if (r.buttons[BTN_COIN]) v[7] = 1'b0;
          if (r.buttons[BTN_LEFT]) v[5] = 1'b0;
          if (r.buttons[BTN_RIGHT]) v[4] = 1'b0;
          // lockout drops before fire is merged, same read shows fire
          if (fire_lock_q && !r.buttons[BTN_FIRE] && r.buttons[BTN_START]) fire_lock_q = 1'b0;
          if (!fire_lock_q && r.buttons[BTN_FIRE]) begin
            v[3] = 1'b0;
            v[1] = 1'b0;
          end
        end
        ADDR_PORT1: begin
          v = port_cfg.port1_default;
          if (!fire_lock_q && r.buttons[BTN_START]) v[7] = 1'b0;
        end
        ADDR_PORT2: begin
          v = prot_value_q[7] ? port_cfg.port2_default_high : port_cfg.port2_default_low;
          if (r.buttons[BTN_DOWN]) v[6] = 1'b0;
          if (r.buttons[BTN_UP]) v[4] = 1'b0;
        end
        ADDR_PROT: v = prot_value_q;
        default: ;
      endcase
    end else begin
      case (r.bus_address)
        ADDR_SOUND_CMD: snd_latch_q = r.write_byte;
        ADDR_SOUND_IRQ: begin
          if (r.write_byte[IRQ_BIT] && !irq_prev_q) begin
            irq_byte_q = r.write_byte;
            strobe = 1'b1;
          end
          irq_prev_q = r.write_byte[IRQ_BIT];
        end
        ADDR_PROT: begin
          prot_shift_q = {prot_shift_q[7:0], r.write_byte[3:0]};
          a = prot_shift_q[11:8];
          b = prot_shift_q[7:4];
          case (prot_shift_q[3:0])
            PROT_OP_TOGGLE: prot_value_q[7] = ~prot_value_q[7];
            PROT_OP_INC: begin
              inc = {1'b0, a} + 5'd1;
              prot_value_q = {(inc > 5'd15) ? 4'hf : inc[3:0], 4'h0};
            end
            PROT_OP_SUB_BA: prot_value_q = {(b > a) ? b - a : 4'h0, 4'h0};
            PROT_OP_CLEAR:  prot_value_q = 8'h00;
            PROT_OP_SUB_AB: prot_value_q = {(a > b) ? a - b : 4'h0, 4'h0};
            default: ;
          endcase
        end
        ADDR_NMI: ctrl_q[0] = r.write_byte[0];
        ADDR_BACKGROUND: begin
          ctrl_q[1] = r.write_byte[0];
          ctrl_q[3] = 1'b1;
        end
        ADDR_STARS: ctrl_q[2] = r.write_byte[0];
        default: ;
      endcase
    end
    o.read_data        = v;
    o.nmi_enable       = ctrl_q[0];
    o.background_on    = ctrl_q[1];
    o.stars_on         = ctrl_q[2];
    o.play_started     = ctrl_q[3];
    o.sound_command    = snd_latch_q;
    o.sound_irq_value  = irq_byte_q;
    o.sound_irq_strobe = strobe;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %02h got %02h at %0t", name, want, got, $time);
    end
  endtask

  task automatic check_response();
    rsp_t want;
    if (pending_responses.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("response with no request outstanding at %0t", $time);
      return;
    end
    want = pending_responses.pop_front();
    cmp_field("read_data", want.read_data, read_data);
    cmp_field("nmi_enable", 8'(want.nmi_enable), 8'(nmi_enable));
    cmp_field("background_on", 8'(want.background_on), 8'(background_on));
    cmp_field("stars_on", 8'(want.stars_on), 8'(stars_on));
    cmp_field("play_started", 8'(want.play_started), 8'(play_started));
    cmp_field("sound_command", want.sound_command, sound_command);
    cmp_field("sound_irq_value", want.sound_irq_value, sound_irq_value);
    cmp_field("sound_irq_strobe", 8'(want.sound_irq_strobe), 8'(sound_irq_strobe));
  endtask

  // response side: check, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_response();
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(input req_t r, input int idle_pct, input logic chk,
                              input logic [7:0] rd);
    rsp_t e;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    req_type    <= r.req_type;
    bus_address <= r.bus_address;
    write_byte  <= r.write_byte;
    buttons     <= r.buttons;
    do @(posedge clk); while (in_stall);
    compute_io_response(r, e);
    if (chk) e.read_data = rd;
    pending_responses.push_back(e);
  endtask

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_defaults(input cfg_t c, input logic poke_unused);
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           val;
    for (int i = 0; i < 5; i++) begin
      if (i == 4 && !poke_unused) break;
      case (i)
        0: begin idx = CFG_PORT0_DEFAULT; val = c.port0_default; end
        1: begin idx = CFG_PORT1_DEFAULT; val = c.port1_default; end
        2: begin idx = CFG_PORT2_DEFAULT_LOW; val = c.port2_default_low; end
        3: begin idx = CFG_PORT2_DEFAULT_HIGH; val = c.port2_default_high; end
        default: begin idx = CFG_IDX_UNUSED; val = 8'($urandom); end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        CFG_PORT0_DEFAULT:      port_cfg.port0_default = val;
        CFG_PORT1_DEFAULT:      port_cfg.port1_default = val;
        CFG_PORT2_DEFAULT_LOW:  port_cfg.port2_default_low = val;
        CFG_PORT2_DEFAULT_HIGH: port_cfg.port2_default_high = val;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.req_type    = 1'($urandom_range(1));
    r.bus_address = 16'($urandom);
    r.write_byte  = 8'($urandom);
    r.buttons     = BTN_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.req_type = REQ_READ;
      case ($urandom_range(3))
        0: r.bus_address = ADDR_PORT0;
        1: r.bus_address = ADDR_PORT1;
        2: r.bus_address = ADDR_PORT2;
        default: r.bus_address = ADDR_PROT;
      endcase
    end else if (pick < 55) begin
      r.req_type = REQ_WRITE;
      r.bus_address = ADDR_PROT;
      // half the nibbles are opcodes so results move often
      if ($urandom_range(1)) begin
        case ($urandom_range(4))
          0: r.write_byte[3:0] = PROT_OP_TOGGLE;
          1: r.write_byte[3:0] = PROT_OP_INC;
          2: r.write_byte[3:0] = PROT_OP_CLEAR;
          3: r.write_byte[3:0] = PROT_OP_SUB_BA;
          default: r.write_byte[3:0] = PROT_OP_SUB_AB;
        endcase
      end
    end else if (pick < 65) begin
      r.req_type = REQ_WRITE;
      r.bus_address = ADDR_SOUND_IRQ;
    end else if (pick < 80) begin
      r.req_type = REQ_WRITE;
      case ($urandom_range(3))
        0: r.bus_address = ADDR_NMI;
        1: r.bus_address = ADDR_BACKGROUND;
        2: r.bus_address = ADDR_STARS;
        default: r.bus_address = ADDR_SOUND_CMD;
      endcase
    end else if (pick < 90) begin
      // neighbors of mapped addresses
      case ($urandom_range(2))
        0: r.bus_address = {8'h98, 8'($urandom_range(7))};
        1: r.bus_address = {8'ha0, 8'($urandom_range(7))};
        default: r.bus_address = {8'ha8, 8'($urandom_range(7))};
      endcase
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic t, input logic [15:0] ad, input logic [7:0] d,
                                      input logic [BTN_W-1:0] bt, input logic chk,
                                      input logic [7:0] rd);
    dir_row_t w;
    w.rq.req_type    = t;
    w.rq.bus_address = ad;
    w.rq.write_byte  = d;
    w.rq.buttons     = bt;
    w.chk            = chk;
    w.rd             = rd;
    return w;
  endfunction

  initial begin
    cfg_t c;
    int   idle_pct;
    // lockout held, then released by start alone
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT0,       8'h00, 7'h00, 1'b1, 8'hff));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT0,       8'h00, 7'h7f, 1'b1, 8'h4f));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT1,       8'h00, 7'h10, 1'b1, 8'hff));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT2,       8'h00, 7'h60, 1'b1, 8'haf));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PROT,        8'h00, 7'h00, 1'b1, 8'h00));
    dir_rows.push_back(mk_row(REQ_READ,  16'h0000,         8'h00, 7'h00, 1'b1, 8'hff));
    dir_rows.push_back(mk_row(REQ_READ,  16'hffff,         8'hff, 7'h7f, 1'b1, 8'hff));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT0,       8'h00, 7'h18, 1'b1, 8'hff));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT0,       8'h00, 7'h10, 1'b1, 8'hff));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT0,       8'h00, 7'h08, 1'b1, 8'hf5));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PORT1,       8'h00, 7'h10, 1'b1, 8'h7f));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_SOUND_CMD,   8'ha5, 7'h00, 1'b0, 8'h00));
    // irq edge, held high, dropped, and a byte without the line bit
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_SOUND_IRQ,   8'h08, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_SOUND_IRQ,   8'hff, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_SOUND_IRQ,   8'h00, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_SOUND_IRQ,   8'hf7, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_NMI,         8'h01, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_BACKGROUND,  8'h00, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_STARS,       8'hff, 7'h7f, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, 16'hffff,         8'hff, 7'h00, 1'b0, 8'h00));
    // protection: toggle, floors at zero, saturating increment, clear, b minus a
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_PROT,        8'h06, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PROT,        8'h00, 7'h00, 1'b1, 8'h80));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_PROT,        8'hff, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_PROT,        8'hff, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_PROT,        8'h09, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PROT,        8'h00, 7'h00, 1'b1, 8'hf0));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_PROT,        8'h0a, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_WRITE, ADDR_PROT,        8'h5b, 7'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(REQ_READ,  ADDR_PROT,        8'h00, 7'h00, 1'b1, 8'h10));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, 0, dir_rows[i].chk, dir_rows[i].rd);
    wait_drained(4);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: c = {8'h00, 8'h00, 8'h00, 8'hff};
        1: c = {8'hff, 8'hff, 8'hff, 8'h00};
        default: c = $urandom;
      endcase
      program_defaults(c, ph == 3);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        3: begin idle_pct = 25; stall_pct = 25; end
        4: begin idle_pct = 0;  stall_pct = 0;  end
        default: begin idle_pct = 40; stall_pct = 10; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long receiver hold while requests keep coming, backs up the input
        if (ph == 4 && k == 10) hold_ticket++;
        if (ph == 5 && k == PHASE_ITEMS / 2) wait_drained(0);
        send_request(random_request(), idle_pct, 1'b0, 8'h00);
      end
      wait_drained(4);
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/aiop_pkg.sv
rtl/aiop_cfg.sv
rtl/aiop_core.sv
rtl/arcade_io_page_with_protection.sv
verif/tb_arcade_io_page_with_protection.sv
